// ===== sv/fpi_pkg.sv =====
// Package for the farthest point in interval block: default depth and
// value width, and the opcodes. No dependencies.
`default_nettype none
package fpi_pkg;
  localparam int MaxElementsDefault = 1024;
  localparam int ValueBitsDefault = 30;
  localparam logic OpLoad = 1'b0;
  localparam logic OpQuery = 1'b1;
endpackage
`default_nettype wire

// ===== sv/fpi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module fpi_ram #(
  parameter int Width = 30,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/fpi_ctrl.sv =====
// Sequencer for the farthest point in interval block: sorted insertion and
// the query scan over the store. Depends on fpi_pkg and drives fpi_ram.
`default_nettype none
module fpi_ctrl
  import fpi_pkg::*;
#(
  parameter int MaxElements = MaxElementsDefault,
  parameter int ValueBits = ValueBitsDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic                 in_first,
  input  wire logic [ValueBits-1:0] in_value,
  input  wire logic [ValueBits-1:0] in_lo,
  input  wire logic [ValueBits-1:0] in_hi,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ValueBits-1:0]      out_point,
  output logic [ValueBits-1:0]      out_dist,
  output logic                      out_empty,
  output logic                      out_ovf,
  output logic                      mem_we,
  output logic [$clog2(MaxElements)-1:0] mem_waddr,
  output logic [ValueBits-1:0]      mem_wdata,
  output logic [$clog2(MaxElements)-1:0] mem_raddr,
  input  wire logic [ValueBits-1:0] mem_rdata
);
  localparam int AW = $clog2(MaxElements);
  localparam int CW = $clog2(MaxElements + 1);
  localparam int VW = ValueBits;
  localparam logic [2:0] StIdle = 3'd0, StIns = 3'd1, StQry = 3'd2,
                         StMid = 3'd3, StOut = 3'd4;
  localparam logic [CW-1:0] CountMax = CW'(MaxElements);

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] pos;
  logic [VW-1:0] val, lo, hi;
  logic [VW-1:0] prev;
  logic          have_prev;
  logic [VW-1:0] dlo, dhi;
  logic [VW-1:0] bpt, bd;

  // In StIns, StQry and StMid the read data x is always entry pos-1. The
  // read address is therefore the entry needed in the following cycle:
  // pos-2 while shifting down, pos while scanning up, and the first entry
  // of the next walk when a walk is about to start.
  assign in_ready = (state == StIdle) && !out_valid;

  always_comb begin
    case (state)
      StIdle:  mem_raddr = (in_op == OpQuery) ? '0 : AW'(count - CW'(1));
      StIns:   mem_raddr = AW'(pos - CW'(2));
      StQry:   mem_raddr = (pos == count) ? '0 : AW'(pos);
      default: mem_raddr = AW'(pos);
    endcase
  end

  logic [VW-1:0] x;
  logic [VW-1:0] ad_lo, ad_hi;
  logic [VW:0]   sum;
  logic [VW-1:0] mid, dl, dr, dm;
  logic          mid_in;
  assign x = mem_rdata;
  assign ad_lo = (x > lo) ? x - lo : lo - x;
  assign ad_hi = (x > hi) ? x - hi : hi - x;
  assign sum = {1'b0, prev} + {1'b0, x};
  assign mid = sum[VW:1];
  assign dl = mid - prev;
  assign dr = x - mid;
  assign dm = (dl < dr) ? dl : dr;
  assign mid_in = (mid >= lo) && (mid < hi);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = AW'(pos);
    mem_wdata = val;
    if (state == StIns) begin
      mem_we = 1'b1;
      if (pos != '0 && x > val) mem_wdata = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      count <= '0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (in_valid && in_ready) begin
            if (in_op == OpLoad) begin
              if (in_first) begin
                if (CountMax == '0) ovf <= 1'b1;
                else begin
                  ovf <= 1'b0; count <= '0; pos <= '0; val <= in_value;
                  state <= StIns;
                end
              end else if (count == CountMax) begin
                ovf <= 1'b1;
              end else begin
                pos <= count; val <= in_value; state <= StIns;
              end
            end else begin
              lo <= (in_lo > in_hi) ? in_hi : in_lo;
              hi <= (in_lo > in_hi) ? in_lo : in_hi;
              if (count == '0) begin
                out_point <= '0; out_dist <= '0; out_empty <= 1'b1;
                out_ovf <= ovf; out_valid <= 1'b1;
              end else begin
                pos <= CW'(1); have_prev <= 1'b0; state <= StQry;
              end
            end
          end
        end
        StIns: begin
          // x is entry pos-1; a larger entry moves up into pos.
          if (pos != '0 && x > val) pos <= pos - CW'(1);
          else begin
            count <= count + CW'(1);
            state <= StIdle;
          end
        end
        StQry: begin
          // x is entry pos-1
          if (!have_prev) begin
            dlo <= ad_lo; dhi <= ad_hi;
          end else begin
            if (ad_lo < dlo) dlo <= ad_lo;
            if (ad_hi < dhi) dhi <= ad_hi;
          end
          if (pos == count) begin
            state <= StMid; pos <= CW'(1); have_prev <= 1'b0;
          end else begin
            pos <= pos + CW'(1); have_prev <= 1'b1;
          end
        end
        StMid: begin
          if (!have_prev) begin
            if (dhi > dlo) begin bd <= dhi; bpt <= hi; end
            else begin bd <= dlo; bpt <= lo; end
          end else if (mid_in && dm > bd) begin
            bd <= dm; bpt <= mid;
          end
          prev <= x;
          have_prev <= 1'b1;
          if (pos == count) state <= StOut;
          else pos <= pos + CW'(1);
        end
        StOut: begin
          out_point <= bpt; out_dist <= bd; out_empty <= 1'b0;
          out_ovf <= ovf; out_valid <= 1'b1; state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/farthest_point_in_interval.sv =====
// Top level of the farthest point in interval block.
// Depends on fpi_pkg, fpi_ctrl and fpi_ram.
//
// Channel  Dir  Beat contents
// s_axis   in   tdata: value, range_low, range_high; tuser: op, first_of_set
// m_axis   out  tdata: best_point, best_distance; tuser: set_empty, overflow
//
// A load inserts its value in ascending order, moving each larger entry
// up by one place. A query walks the store twice through its single read
// port, once for the nearest distances and once for the midpoints. The
// block takes no new beat while a load or a query is in progress. rst is
// synchronous and clears the count, the overflow flag and the sequencer;
// store contents need no reset. A result waits in its output register
// while m_axis_tready is low and the block takes no new beat until it has
// left.
`default_nettype none
module farthest_point_in_interval
  import fpi_pkg::*;
#(
  parameter int MAX_ELEMENTS = MaxElementsDefault,
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // value [VB-1:0], range_low, range_high, zero pad to bytes
  input  wire logic [((3*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op [0], first_of_set [1]
  input  wire logic [1:0] s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // best_point [VB-1:0], best_distance, zero pad to bytes
  output logic [((2*VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // set_empty [0], store_overflowed [1]
  output logic [1:0] m_axis_tuser
);
  localparam int VB = VALUE_BITS;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int OW = ((2*VALUE_BITS+7)/8)*8;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VB-1:0] wdata, rdata;
  logic [VB-1:0] pt, best_d;

  fpi_ctrl #(.MaxElements(MAX_ELEMENTS), .ValueBits(VALUE_BITS)) u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tuser[0]), .in_first(s_axis_tuser[1]),
    .in_value(s_axis_tdata[VB-1:0]),
    .in_lo(s_axis_tdata[2*VB-1:VB]),
    .in_hi(s_axis_tdata[3*VB-1:2*VB]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_point(pt), .out_dist(best_d),
    .out_empty(m_axis_tuser[0]), .out_ovf(m_axis_tuser[1]),
    .mem_we(we), .mem_waddr(waddr), .mem_wdata(wdata),
    .mem_raddr(raddr), .mem_rdata(rdata)
  );

  // Sorted store of the loaded elements.
  fpi_ram #(.Width(VB), .Depth(MAX_ELEMENTS)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign m_axis_tdata = OW'({best_d, pt});
endmodule
`default_nettype wire
